@@ sv/preamble_frame_receiver_unit_defines.svh @@
// assertion macros used by the result stage module
`ifndef PREAMBLE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define PREAMBLE_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTH
// condition implies consequence in the same cycle
`define PRFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prfr assertion failed");
// condition implies consequence in the next cycle
`define PRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prfr assertion failed");
`else
`define PRFR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/prfr_pkg.sv @@
package prfr_pkg;

    // result event codes
    typedef enum logic [1:0] {
        EV_HDR_OK    = 2'd0,
        EV_PAYLOAD   = 2'd1,
        EV_FRAME_END = 2'd2,
        EV_HDR_ERR   = 2'd3
    } event_t;

    // configuration register indexes
    localparam logic REG_PREAMBLE_VALUE = 1'b0;
    localparam logic REG_PREAMBLE_COUNT = 1'b1;

    localparam logic [7:0]  PREAMBLE_VALUE_RST = 8'h55;
    localparam logic [3:0]  PREAMBLE_COUNT_RST = 4'd10;
    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY           = 16'hA001;

    // classified word handed from the parser to the result stage
    typedef struct packed {
        event_t      kind;
        logic [15:0] addr;
        logic [7:0]  req;
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [15:0] data;
    } tok_t;

    typedef struct packed {
        event_t      event_res;
        logic [15:0] dev_addr;
        logic [7:0]  req_num;
        logic [7:0]  command;
        logic [7:0]  data_len;
        logic [7:0]  payload_byte;
        logic [15:0] data_crc;
        logic        data_crc_ok;
        logic        frame_last;
    } res_t;

    // reflected crc-16, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/prfr_front.sv @@
module prfr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_take,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       pre_value,
    input  logic [3:0]       pre_count,
    output logic             tok_valid,
    output prfr_pkg::tok_t   tok
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_FILLER  = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRCLO   = 3'd4,
        PH_CRCHI   = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  run_reg, run_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  req_reg, req_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  crclo_reg, crclo_next;
    logic [15:0] hcrc_reg, hcrc_next;
    logic [7:0]  left_reg, left_next;

    logic [3:0]  need;
    logic [4:0]  run_inc;
    logic [15:0] rx_crc;

    assign need    = (pre_count == 4'd0) ? 4'd1 : pre_count;
    assign run_inc = {1'b0, run_reg} + 5'd1;
    assign rx_crc  = {rx_byte, crclo_reg};

    always_comb
    begin
        phase_next = phase_reg;
        run_next   = run_reg;
        hidx_next  = hidx_reg;
        addr_next  = addr_reg;
        req_next   = req_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        crclo_next = crclo_reg;
        hcrc_next  = hcrc_reg;
        left_next  = left_reg;
        tok_valid  = 1'b0;
        tok.kind   = prfr_pkg::EV_HDR_OK;
        tok.addr   = addr_reg;
        tok.req    = req_reg;
        tok.cmd    = cmd_reg;
        tok.len    = len_reg;
        tok.data   = 16'h0000;

        if (in_take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == pre_value)
                    begin
                        if (run_inc >= {1'b0, need})
                        begin
                            run_next   = 4'd0;
                            phase_next = PH_FILLER;
                        end
                        else
                        begin
                            run_next = run_inc[3:0];
                        end
                    end
                    else
                    begin
                        run_next = 4'd0;
                    end
                end
                PH_FILLER:
                begin
                    hidx_next  = 3'd0;
                    hcrc_next  = prfr_pkg::CRC_INIT;
                    phase_next = PH_HEADER;
                end
                PH_HEADER:
                begin
                    case (hidx_reg)
                        3'd0: addr_next  = {8'h00, rx_byte};
                        3'd1: addr_next  = {rx_byte, addr_reg[7:0]};
                        3'd2: req_next   = rx_byte;
                        3'd3: cmd_next   = rx_byte;
                        3'd4: len_next   = rx_byte;
                        3'd5: crclo_next = rx_byte;
                        default: ;
                    endcase
                    if (hidx_reg <= 3'd4)
                    begin
                        hcrc_next = prfr_pkg::crc_step(hcrc_reg, rx_byte);
                    end
                    if (hidx_reg < 3'd6)
                    begin
                        hidx_next = hidx_reg + 3'd1;
                    end
                    else
                    begin
                        hidx_next = 3'd0;
                        tok_valid = 1'b1;
                        if (rx_crc != hcrc_reg)
                        begin
                            phase_next = PH_HUNT;
                            run_next   = 4'd0;
                            tok.kind   = prfr_pkg::EV_HDR_ERR;
                        end
                        else
                        begin
                            hcrc_next  = prfr_pkg::CRC_INIT;
                            left_next  = (len_reg >= 8'd2) ? len_reg - 8'd2 : 8'd0;
                            phase_next = (len_reg > 8'd2) ? PH_PAYLOAD : PH_CRCLO;
                            tok.kind   = prfr_pkg::EV_HDR_OK;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_CRCLO;
                    end
                    tok_valid = 1'b1;
                    tok.kind  = prfr_pkg::EV_PAYLOAD;
                    tok.data  = {8'h00, rx_byte};
                end
                PH_CRCLO:
                begin
                    crclo_next = rx_byte;
                    phase_next = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    phase_next = PH_HUNT;
                    run_next   = 4'd0;
                    tok_valid  = 1'b1;
                    tok.kind   = prfr_pkg::EV_FRAME_END;
                    tok.data   = rx_crc;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    run_next   = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            run_reg   <= 4'd0;
            hidx_reg  <= 3'd0;
            addr_reg  <= 16'h0000;
            req_reg   <= 8'h00;
            cmd_reg   <= 8'h00;
            len_reg   <= 8'h00;
            crclo_reg <= 8'h00;
            hcrc_reg  <= prfr_pkg::CRC_INIT;
            left_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
            hidx_reg  <= hidx_next;
            addr_reg  <= addr_next;
            req_reg   <= req_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            crclo_reg <= crclo_next;
            hcrc_reg  <= hcrc_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ sv/prfr_queue.sv @@
module prfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  prfr_pkg::tok_t wr_tok,
    output logic           q_full,
    output logic           q_empty,
    input  logic           rd_en,
    output prfr_pkg::tok_t rd_tok
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    prfr_pkg::tok_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_tok  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_tok;
        end
    end

endmodule

@@ sv/prfr_back.sv @@
`include "preamble_frame_receiver_unit_defines.svh"

module prfr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  prfr_pkg::tok_t q_tok,
    output logic           q_pop,
    input  logic           res_pop,
    output logic           res_valid,
    output prfr_pkg::res_t res
);

    logic           out_valid_reg, out_valid_next;
    prfr_pkg::res_t res_reg, res_next;
    logic [15:0]    dcrc_reg, dcrc_next;
    logic           is_end;

    assign q_pop     = !q_empty && (!out_valid_reg || res_pop);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;
    assign is_end    = (q_tok.kind == prfr_pkg::EV_FRAME_END);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        dcrc_next      = dcrc_reg;
        if (out_valid_reg && res_pop)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            out_valid_next        = 1'b1;
            res_next.event_res    = q_tok.kind;
            res_next.dev_addr     = q_tok.addr;
            res_next.req_num      = q_tok.req;
            res_next.command      = q_tok.cmd;
            res_next.data_len     = q_tok.len;
            res_next.payload_byte = (q_tok.kind == prfr_pkg::EV_PAYLOAD) ?
                                    q_tok.data[7:0] : 8'h00;
            res_next.data_crc     = is_end ? q_tok.data : 16'h0000;
            res_next.data_crc_ok  = is_end && (q_tok.data == dcrc_reg);
            res_next.frame_last   = is_end || (q_tok.kind == prfr_pkg::EV_HDR_ERR);
            case (q_tok.kind)
                prfr_pkg::EV_HDR_OK:  dcrc_next = prfr_pkg::CRC_INIT;
                prfr_pkg::EV_PAYLOAD: dcrc_next = prfr_pkg::crc_step(dcrc_reg,
                                                                     q_tok.data[7:0]);
                default:              dcrc_next = dcrc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dcrc_reg      <= prfr_pkg::CRC_INIT;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            dcrc_reg      <= dcrc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    `PRFR_ASSERT_NEXT(a_hdr_resets_crc, clk, rst_n, q_pop && (q_tok.kind == prfr_pkg::EV_HDR_OK), dcrc_reg == prfr_pkg::CRC_INIT)
    `PRFR_ASSERT_NEXT(a_pop_fills_out, clk, rst_n, q_pop, out_valid_reg)
    `PRFR_ASSERT_SAME(a_ok_only_at_end, clk, rst_n, out_valid_reg && res_reg.data_crc_ok, res_reg.event_res == prfr_pkg::EV_FRAME_END)

endmodule

@@ sv/preamble_frame_receiver_unit.sv @@
// channel   | direction | handshake                  | contents
// ----------+-----------+----------------------------+------------------------------------
// input     | in        | push / full                | rx_byte, one received serial byte
// result    | out       | empty / pop                | event_res, header fields, payload
//           |           |                            | byte, data crc, crc check, last
// config    | in        | cfg_we (no wait)           | cfg_idx, cfg_data
//
// one byte is taken per cycle while full is low; a byte that yields a result
// word writes a token into the token queue; the result register then takes it
// the parser and the result register are split by a small token queue, so a
// held result word stalls only once that queue fills (full goes high)
// reset is asynchronous and active low; it empties the token queue and the result
// register, restarts the preamble hunt and restores the preamble registers to 0x55 and 10
module preamble_frame_receiver_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_res,
    output logic [15:0] dev_addr,
    output logic [7:0]  req_num,
    output logic [7:0]  command,
    output logic [7:0]  data_len,
    output logic [7:0]  payload_byte,
    output logic [15:0] data_crc,
    output logic        data_crc_ok,
    output logic        frame_last,
    // register writes
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [7:0]  cfg_data
);

    logic [7:0]     pre_value_reg;
    logic [3:0]     pre_count_reg;

    logic           in_take;
    logic           tok_valid;
    prfr_pkg::tok_t tok_wr;
    prfr_pkg::tok_t tok_rd;
    logic           q_full, q_empty, q_pop;
    logic           res_valid;
    prfr_pkg::res_t res;

    // byte is taken only while the token queue has room
    assign full    = q_full;
    assign in_take = push && !q_full;

    // preamble registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_value_reg <= prfr_pkg::PREAMBLE_VALUE_RST;
            pre_count_reg <= prfr_pkg::PREAMBLE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                prfr_pkg::REG_PREAMBLE_VALUE: pre_value_reg <= cfg_data;
                prfr_pkg::REG_PREAMBLE_COUNT: pre_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // parser: preamble hunt, header collect and header crc check, then payload and data crc bytes
    prfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .rx_byte   (rx_byte),
        .pre_value (pre_value_reg),
        .pre_count (pre_count_reg),
        .tok_valid (tok_valid),
        .tok       (tok_wr)
    );

    // tokens waiting for the result stage
    prfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_valid),
        .wr_tok  (tok_wr),
        .q_full  (q_full),
        .q_empty (q_empty),
        .rd_en   (q_pop),
        .rd_tok  (tok_rd)
    );

    // result stage: payload crc and the output word register
    prfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_tok     (tok_rd),
        .q_pop     (q_pop),
        .res_pop   (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty        = !res_valid;
    assign event_res    = res.event_res;
    assign dev_addr     = res.dev_addr;
    assign req_num      = res.req_num;
    assign command      = res.command;
    assign data_len     = res.data_len;
    assign payload_byte = res.payload_byte;
    assign data_crc     = res.data_crc;
    assign data_crc_ok  = res.data_crc_ok;
    assign frame_last   = res.frame_last;

endmodule

@@ bench/tb_preamble_frame_receiver_unit.sv @@
module tb_preamble_frame_receiver_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // receiver phases of the local deframer copy
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FILLER,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } rx_phase_t;

    // settle time after the last result word before a register write or the end
    localparam int DRAIN_CYCLES = 12;
    // receiver hold-off used to back up the block
    localparam int HOLD_OFF_CYCLES = 300;
    // random input bytes per register setting
    localparam int BYTES_PER_SETTING = 240;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  event_res;
    logic [15:0] dev_addr;
    logic [7:0]  req_num;
    logic [7:0]  command;
    logic [7:0]  data_len;
    logic [7:0]  payload_byte;
    logic [15:0] data_crc;
    logic        data_crc_ok;
    logic        frame_last;
    logic        cfg_we;
    logic        cfg_idx;
    logic [7:0]  cfg_data;

    preamble_frame_receiver_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .event_res    (event_res),
        .dev_addr     (dev_addr),
        .req_num      (req_num),
        .command      (command),
        .data_len     (data_len),
        .payload_byte (payload_byte),
        .data_crc     (data_crc),
        .data_crc_ok  (data_crc_ok),
        .frame_last   (frame_last),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // local deframer: register copies and receive state
    // ------------------------------------------------------------------
    logic [7:0]  pre_value;
    logic [3:0]  pre_count;
    rx_phase_t   st_phase;
    logic [3:0]  st_run;
    logic [2:0]  st_hdr_idx;
    logic [15:0] st_addr;
    logic [7:0]  st_req;
    logic [7:0]  st_cmd;
    logic [7:0]  st_len;
    logic [7:0]  st_crc_lo;
    logic [15:0] st_crc;
    logic [7:0]  st_left;

    // result words still owed by the block, oldest first
    prfr_pkg::res_t pending_events[$];

    int  fail_count;
    int  bytes_sent;
    bit  steady;        // no random idling on either side while set
    int  hold_cycles;   // receiver hold-off request, consumed by the pop process
    int  pop_idle_left;

    // reflected crc-16 over one byte, bit-serial
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ({1'b0, c[15:1]} ^ prfr_pkg::CRC_POLY) : {1'b0, c[15:1]};
        end
        return c;
    endfunction

    function automatic prfr_pkg::res_t make_event(input prfr_pkg::event_t ev,
                                                  input logic [7:0] pb,
                                                  input logic [15:0] dcrc, input logic ok,
                                                  input logic last);
        prfr_pkg::res_t r;
        r.event_res    = ev;
        r.dev_addr     = st_addr;
        r.req_num      = st_req;
        r.command      = st_cmd;
        r.data_len     = st_len;
        r.payload_byte = pb;
        r.data_crc     = dcrc;
        r.data_crc_ok  = ok;
        r.frame_last   = last;
        return r;
    endfunction

    task automatic reset_deframer();
        pre_value  = prfr_pkg::PREAMBLE_VALUE_RST;
        pre_count  = prfr_pkg::PREAMBLE_COUNT_RST;
        st_phase   = PH_HUNT;
        st_run     = '0;
        st_hdr_idx = '0;
        st_addr    = '0;
        st_req     = '0;
        st_cmd     = '0;
        st_len     = '0;
        st_crc_lo  = '0;
        st_crc     = prfr_pkg::CRC_INIT;
        st_left    = '0;
    endtask

    // advance the local deframer by one accepted byte, queue any result word
    task automatic deframe_byte(input logic [7:0] b);
        int          need;
        logic [15:0] rx;
        need = (pre_count == 4'd0) ? 1 : int'(pre_count);
        case (st_phase)
            PH_HUNT:
            begin
                if (b == pre_value)
                begin
                    if (int'(st_run) + 1 >= need)
                    begin
                        st_run   = '0;
                        st_phase = PH_FILLER;
                    end
                    else
                    begin
                        st_run = st_run + 4'd1;
                    end
                end
                else
                begin
                    st_run = '0;
                end
            end
            PH_FILLER:
            begin
                st_hdr_idx = '0;
                st_crc     = prfr_pkg::CRC_INIT;
                st_phase   = PH_HEADER;
            end
            PH_HEADER:
            begin
                case (st_hdr_idx)
                    3'd0: st_addr = {8'h00, b};
                    3'd1: st_addr[15:8] = b;
                    3'd2: st_req = b;
                    3'd3: st_cmd = b;
                    3'd4: st_len = b;
                    3'd5: st_crc_lo = b;
                    default: ;
                endcase
                if (st_hdr_idx <= 3'd4)
                begin
                    st_crc = crc16_byte(st_crc, b);
                end
                if (st_hdr_idx < 3'd6)
                begin
                    st_hdr_idx = st_hdr_idx + 3'd1;
                end
                else
                begin
                    st_hdr_idx = '0;
                    rx = {b, st_crc_lo};
                    if (rx != st_crc)
                    begin
                        st_phase = PH_HUNT;
                        st_run   = '0;
                        pending_events.push_back(
                            make_event(prfr_pkg::EV_HDR_ERR, 8'h00, 16'h0000,
                                       1'b0, 1'b1));
                    end
                    else
                    begin
                        st_crc   = prfr_pkg::CRC_INIT;
                        st_left  = (st_len >= 8'd2) ? st_len - 8'd2 : 8'd0;
                        st_phase = (st_left != 8'd0) ? PH_PAYLOAD : PH_CRC_LO;
                        pending_events.push_back(
                            make_event(prfr_pkg::EV_HDR_OK, 8'h00, 16'h0000,
                                       1'b0, 1'b0));
                    end
                end
            end
            PH_PAYLOAD:
            begin
                st_crc  = crc16_byte(st_crc, b);
                st_left = st_left - 8'd1;
                if (st_left == 8'd0)
                begin
                    st_phase = PH_CRC_LO;
                end
                pending_events.push_back(make_event(prfr_pkg::EV_PAYLOAD, b, 16'h0000,
                                                    1'b0, 1'b0));
            end
            PH_CRC_LO:
            begin
                st_crc_lo = b;
                st_phase  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                rx       = {b, st_crc_lo};
                st_phase = PH_HUNT;
                st_run   = '0;
                pending_events.push_back(make_event(prfr_pkg::EV_FRAME_END, 8'h00, rx,
                                                    rx == st_crc, 1'b1));
            end
            default:
            begin
                st_phase = PH_HUNT;
                st_run   = '0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // idle pattern shared by sender and receiver: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // sender: one byte per call, entered and left at a falling edge
    // push stays high when the next byte follows with no gap
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        // the byte is taken at the first rising edge with full low
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        deframe_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // drop push, let every owed word come out, then let the parser settle
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_events.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write while idle; the trailing wait keeps cfg_we edges apart
    task automatic write_reg(input logic idx, input logic [7:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == prfr_pkg::REG_PREAMBLE_VALUE)
        begin
            pre_value = data;
        end
        else
        begin
            pre_count = data[3:0];
        end
        @(negedge clk);
    endtask

    // count register written with junk in the unused upper bits
    task automatic configure(input logic [7:0] value, input logic [3:0] count);
        wait_idle();
        write_reg(prfr_pkg::REG_PREAMBLE_VALUE, value);
        write_reg(prfr_pkg::REG_PREAMBLE_COUNT, {4'($urandom_range(0, 15)), count});
    endtask

    // any byte that does not match the preamble value
    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == pre_value)
        begin
            b = ~b;
        end
        return b;
    endfunction

    task automatic send_preamble();
        int n;
        n = (pre_count == 4'd0) ? 1 : int'(pre_count);
        repeat (n) send_byte(pre_value);
    endtask

    // filler, header with its crc, then payload and data crc unless the header crc is broken
    task automatic send_frame_body(input logic [15:0] addr, input logic [7:0] req,
                                   input logic [7:0] cmd, input logic [7:0] len,
                                   input bit bad_hdr, input bit bad_data);
        logic [39:0] hdr;
        logic [15:0] crc;
        logic [7:0]  b;
        int          n;
        hdr = {len, cmd, req, addr};
        send_byte(8'($urandom_range(0, 255)));
        crc = prfr_pkg::CRC_INIT;
        for (int i = 0; i < 5; i++)
        begin
            crc = crc16_byte(crc, hdr[8*i +: 8]);
            send_byte(hdr[8*i +: 8]);
        end
        if (bad_hdr)
        begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        if (bad_hdr)
        begin
            return;
        end
        n = (len >= 8'd2) ? int'(len) - 2 : 0;
        crc = prfr_pkg::CRC_INIT;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            crc = crc16_byte(crc, b);
            send_byte(b);
        end
        if (bad_data)
        begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic send_frame(input logic [15:0] addr, input logic [7:0] req,
                              input logic [7:0] cmd, input logic [7:0] len,
                              input bit bad_hdr, input bit bad_data);
        send_preamble();
        send_frame_body(addr, req, cmd, len, bad_hdr, bad_data);
    endtask

    // mostly short payloads, now and then a long one
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return 8'($urandom_range(0, 1));
        end
        if (r < 90)
        begin
            return 8'($urandom_range(2, 14));
        end
        if (r < 97)
        begin
            return 8'($urandom_range(15, 40));
        end
        return 8'($urandom_range(200, 255));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values of both registers: 0x55 run of ten starts the frame
    task automatic test_reset_defaults();
        send_frame(16'h1234, 8'h01, 8'h03, 8'd5, 1'b0, 1'b0);
    endtask

    // header field extremes, empty payloads, length below two, bad data crc
    task automatic test_field_extremes();
        configure(8'h00, 4'd1);
        send_frame(16'hFFFF, 8'hFF, 8'hFF, 8'd2, 1'b0, 1'b0);
        send_frame(16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1);
        send_frame(16'h00FF, 8'h80, 8'h7F, 8'd1, 1'b0, 1'b0);
        send_frame(16'hFF00, 8'h55, 8'hAA, 8'd3, 1'b0, 1'b1);
    endtask

    // broken header crc reports the fields and goes back to the hunt
    task automatic test_header_error();
        configure(8'hFF, 4'd2);
        send_frame(16'hBEEF, 8'h12, 8'h34, 8'd4, 1'b1, 1'b0);
        send_frame(16'h0001, 8'h02, 8'h03, 8'd3, 1'b0, 1'b0);
    endtask

    // mismatch restarts the run; lowering the count below the run
    // lets the next matching byte start the frame
    task automatic test_hunt_restart();
        configure(8'hA5, 4'd3);
        send_byte(pre_value);
        send_byte(pre_value);
        send_byte(other_byte());
        send_frame(16'h4321, 8'h07, 8'h09, 8'd2, 1'b0, 1'b0);
        configure(8'hA5, 4'd5);
        repeat (4) send_byte(pre_value);
        wait_idle();
        write_reg(prfr_pkg::REG_PREAMBLE_COUNT, 8'd2);
        send_byte(pre_value);
        send_frame_body(16'h5A5A, 8'h11, 8'h22, 8'd3, 1'b0, 1'b0);
    endtask

    // a count of zero acts as a count of one
    task automatic test_count_zero();
        configure(8'hFF, 4'd0);
        send_frame(16'h8001, 8'hFE, 8'h01, 8'd4, 1'b0, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering a long frame,
    // the token queue fills and full must stall the input side
    task automatic test_input_stall();
        configure(8'h55, 4'd4);
        steady      = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
        send_frame(16'hC0DE, 8'h33, 8'h44, 8'd60, 1'b0, 1'b0);
        steady = 1'b0;
        wait_idle();
    endtask

    // random frames with random content, plus noise and broken preambles
    task automatic test_random_traffic();
        int start;
        int r;
        int n;
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: configure(prfr_pkg::PREAMBLE_VALUE_RST, prfr_pkg::PREAMBLE_COUNT_RST);
                1: configure(8'h00, 4'd1);
                2: configure(8'hFF, 4'd15);
                3: configure(8'($urandom_range(0, 255)), 4'd0);
                default: configure(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)));
            endcase
            // one setting runs with both sides always ready
            steady = (s == 2);
            start  = bytes_sent;
            while (bytes_sent - start < BYTES_PER_SETTING)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                begin
                    send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), pick_len(), 1'b0,
                               $urandom_range(0, 9) == 0);
                end
                else if (r < 86)
                begin
                    send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), pick_len(), 1'b1, 1'b0);
                end
                else if (r < 93)
                begin
                    // line noise, part of it looking like preamble
                    repeat ($urandom_range(1, 6))
                    begin
                        send_byte(($urandom_range(0, 9) < 4) ? pre_value
                                  : 8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    // preamble cut short by a stray byte
                    n = (pre_count == 4'd0) ? 1 : int'(pre_count);
                    if (n > 1)
                    begin
                        repeat ($urandom_range(1, n - 1)) send_byte(pre_value);
                    end
                    send_byte(other_byte());
                end
            end
            steady = 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // receiver: random pop pattern, with the requested hold-off
    // ------------------------------------------------------------------
    initial
    begin
        pop           = 1'b0;
        pop_idle_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                // long stretch with pop low, counted here
                pop <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else if (pop_idle_left != 0)
            begin
                pop <= 1'b0;
                pop_idle_left--;
            end
            else
            begin
                pop <= 1'b1;
                pop_idle_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // each accepted result word against the oldest owed one
    always @(posedge clk)
    begin
        prfr_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                $error("result word with nothing owed: event %0d", event_res);
                fail_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("event_res", want.event_res, event_res);
                check_field("dev_addr", want.dev_addr, dev_addr);
                check_field("req_num", want.req_num, req_num);
                check_field("command", want.command, command);
                check_field("data_len", want.data_len, data_len);
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("data_crc", want.data_crc, data_crc);
                check_field("data_crc_ok", want.data_crc_ok, data_crc_ok);
                check_field("frame_last", want.frame_last, frame_last);
            end
        end
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        rx_byte     = 8'h00;
        cfg_we      = 1'b0;
        cfg_idx     = prfr_pkg::REG_PREAMBLE_VALUE;
        cfg_data    = 8'h00;
        steady      = 1'b0;
        hold_cycles = 0;
        fail_count  = 0;
        bytes_sent  = 0;
        reset_deframer();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_header_error();
        test_hunt_restart();
        test_count_zero();
        test_input_stall();
        test_random_traffic();

        // everything owed has come out; watch a little longer for strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
